/* design/u8cpd_pkg.sv */
// Package for the UTF-8 code point decoder: beat types, status codes,
// queue sizing and the lead-byte length function. No dependencies.
`default_nettype none

package u8cpd_pkg;

  // Status codes carried on each result beat
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CONT = 2'd1;
  localparam logic [1:0] ST_BAD_LEAD = 2'd2;

  // Most results one input byte can release (a final byte flushing the hold)
  localparam int MAX_RES = 3;
  // Result queue depth: one waiting beat plus a full flush
  localparam int QDEPTH  = 4;
  // Bytes kept while a multi-byte sequence is incomplete
  localparam int HOLD_DEPTH = 3;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [1:0]  status;
    logic        last_of_run;
    logic        string_done;
  } out_t;

  // Everything one byte step produces: results, their count, the new hold
  typedef struct packed {
    out_t [MAX_RES-1:0]        res;
    logic [1:0]                nres;
    logic [HOLD_DEPTH-1:0][7:0] held_bytes;
    logic [1:0]                held_count;
  } step_t;

  // Sequence length implied by a lead byte; 0 marks an unsupported lead
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110 && b <= 8'hF4) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

/* design/u8cpd_step.sv */
// Combinational byte step: joins the held bytes with a new byte and decodes
// up to three code points. Depends on u8cpd_pkg.
`default_nettype none

module u8cpd_step (
  input  wire logic [u8cpd_pkg::HOLD_DEPTH-1:0][7:0] held_bytes,
  input  wire logic [1:0]                           held_count,
  input  wire u8cpd_pkg::in_t                       data,
  output u8cpd_pkg::step_t                          step
);
  import u8cpd_pkg::*;

  always_comb begin
    logic [7:0]  bytes [4];
    logic [2:0]  n;
    logic [2:0]  pos;
    logic [2:0]  len;
    logic [2:0]  avail;
    logic [7:0]  b0;
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [7:0]  c3;
    logic        stop;
    logic        bad;
    logic [20:0] cp;
    logic        fin;

    fin = data.final_byte;

    // Line up the pending bytes with the new byte behind them
    for (int i = 0; i < 4; i++) begin
      if (i < HOLD_DEPTH && 2'(i) < held_count) begin
        bytes[i] = held_bytes[i];
      end else begin
        bytes[i] = data.byte_in;
      end
    end
    n    = {1'b0, held_count} + 3'd1;
    pos  = 3'd0;
    stop = 1'b0;
    step.nres = 2'd0;

    // Decode leads one after another; at most three per byte
    for (int k = 0; k < MAX_RES; k++) begin
      step.res[k] = '0;
      b0    = bytes[pos[1:0]];
      c1    = bytes[pos[1:0] + 2'd1];
      c2    = bytes[pos[1:0] + 2'd2];
      c3    = bytes[pos[1:0] + 2'd3];
      len   = seq_len(b0);
      avail = n - pos;
      cp    = '0;
      bad   = 1'b0;
      if (!stop && pos < n) begin
        if (len == 3'd0) begin
          step.res[k].status = ST_BAD_LEAD;
          step.nres = 2'(k + 1);
          pos = pos + 3'd1;
        end else if (len == 3'd1) begin
          step.res[k].code_point = {14'd0, b0[6:0]};
          step.res[k].status     = ST_OK;
          step.nres = 2'(k + 1);
          pos = pos + 3'd1;
        end else if (avail >= len) begin
          // Complete sequence: take six bits of each follower, flag bad ones
          unique case (len)
            3'd2: begin
              cp  = {10'd0, b0[4:0], c1[5:0]};
              bad = (c1[7:6] != 2'b10);
            end
            3'd3: begin
              cp  = {5'd0, b0[3:0], c1[5:0], c2[5:0]};
              bad = (c1[7:6] != 2'b10) || (c2[7:6] != 2'b10);
            end
            default: begin
              cp  = {b0[2:0], c1[5:0], c2[5:0], c3[5:0]};
              bad = (c1[7:6] != 2'b10) || (c2[7:6] != 2'b10) ||
                    (c3[7:6] != 2'b10);
            end
          endcase
          step.res[k].code_point = cp;
          step.res[k].status     = bad ? ST_BAD_CONT : ST_OK;
          step.nres = 2'(k + 1);
          pos = pos + len;
        end else if (fin) begin
          // Truncated at end of string: drop the lead, rescan what follows
          step.res[k].status = ST_BAD_LEAD;
          step.nres = 2'(k + 1);
          pos = pos + 3'd1;
        end else begin
          stop = 1'b1;
        end
      end
    end

    // Mark the last result of this byte, and of the string
    for (int k = 0; k < MAX_RES; k++) begin
      if (2'(k + 1) == step.nres) begin
        step.res[k].last_of_run = 1'b1;
        step.res[k].string_done = fin;
      end
    end

    // Keep the incomplete tail; a final byte empties the hold
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      step.held_bytes[i] = bytes[pos[1:0] + 2'(i)];
    end
    step.held_count = fin ? 2'd0 : 2'(n - pos);
  end

endmodule

`default_nettype wire

/* design/utf8_codepoint_decoder.sv */
// Top level of the UTF-8 code point decoder: byte hold registers and the
// result queue around the byte step. Depends on u8cpd_pkg and u8cpd_step.
//
//   channel | direction | handshake               | beat
//   --------+-----------+-------------------------+--------------------------
//   byte    | in        | byte_valid / byte_stall | in_t: byte, final flag
//   cp      | out       | cp_valid / cp_stall     | out_t: code point, status
//
// One byte is taken per cycle while byte_stall is low; its results are
// registered in the result queue. A final byte may release up to three
// results, which leave one per cycle while cp_stall is low. byte_stall
// rises while more than one result waits in the four-entry result queue,
// so a flush holds the byte side until the queue is back to one result.
// Reset empties the hold and the result queue.
`default_nettype none

module utf8_codepoint_decoder (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            byte_valid,
  output logic                 byte_stall,
  input  wire u8cpd_pkg::in_t  byte_data,
  output logic                 cp_valid,
  input  wire logic            cp_stall,
  output u8cpd_pkg::out_t      cp_data
);
  import u8cpd_pkg::*;

  logic [HOLD_DEPTH-1:0][7:0] held_bytes;
  logic [1:0]                 held_count;
  out_t                       q      [QDEPTH];
  out_t                       q_next [QDEPTH];
  logic [2:0]                 cnt;
  logic [2:0]                 cnt_next;
  logic [2:0]                 base_cnt;
  logic                       push;
  logic                       pop;
  step_t                      step;

  u8cpd_step u_step (
    .held_bytes (held_bytes),
    .held_count (held_count),
    .data       (byte_data),
    .step       (step)
  );

  // Take a byte only when the queue can absorb a full flush
  assign byte_stall = (cnt > 3'd1);
  assign push       = byte_valid && !byte_stall;
  assign cp_valid   = (cnt != 3'd0);
  assign cp_data    = q[0];
  assign pop        = cp_valid && !cp_stall;

  // Advance the hold on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (push) begin
      held_count <= step.held_count;
    end
    if (push) begin
      held_bytes <= step.held_bytes;
    end
  end

  // Shift out the head beat and append new results behind what remains
  always_comb begin
    base_cnt = cnt - {2'd0, pop};
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        q_next[i] = q[i + 1];
      end else begin
        q_next[i] = q[i];
      end
      if (push && 3'(i) >= base_cnt && 3'(i) < base_cnt + {1'b0, step.nres}) begin
        q_next[i] = step.res[2'(3'(i) - base_cnt)];
      end
    end
    cnt_next = base_cnt + (push ? {1'b0, step.nres} : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else begin
      cnt <= cnt_next;
    end
    for (int i = 0; i < QDEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  // Queue never overfills
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'(QDEPTH))
    else $error("result queue overfilled");

  // A final byte leaves nothing held
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    push && byte_data.final_byte |=> held_count == 2'd0)
    else $error("hold not cleared after final byte");

  // Held bytes always start with an incomplete multi-byte lead
  a_hold_lead: assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd0 |-> seq_len(held_bytes[0]) > 3'd1 &&
                           {1'b0, held_count} < seq_len(held_bytes[0]))
    else $error("held bytes do not begin with a pending lead");

  // A beat taken with no byte arriving shrinks the queue by one
  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> cnt == $past(cnt) - 3'd1)
    else $error("queue count wrong after pop");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking bench for utf8_codepoint_decoder: drives byte beats and checks
// every code point beat against an in-bench UTF-8 decode model.
// Depends on u8cpd_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module testbench;
  import u8cpd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_BYTES = 250;
  localparam int SETTLE_CYCLES = 8;

  logic clk;
  logic rst;
  logic byte_valid;
  logic byte_stall;
  in_t  byte_data;
  logic cp_valid;
  logic cp_stall;
  out_t cp_data;

  // Decode model state: bytes of an incomplete sequence
  logic [7:0] hold_q [0:2];
  int         hold_n = 0;

  out_t       expected_cps[$];
  out_t       cp_want;
  logic [7:0] text_q[$];
  int         error_count = 0;
  int         bytes_sent = 0;
  int         cycle_count = 0;
  int         long_hold = 0;
  bit         no_idle = 1'b0;

  utf8_codepoint_decoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .cp_valid   (cp_valid),
    .cp_stall   (cp_stall),
    .cp_data    (cp_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Idle cycles before a beat; none during quiet stretches
  function automatic int draw_wait();
    if (no_idle || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // Sequence length from a lead byte, 0 for a lead that is not supported
  function automatic int lead_length(input logic [7:0] b);
    casez (b)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return (b <= 8'hF4) ? 4 : 0;
      default:     return 0;
    endcase
  endfunction

  // Decode one accepted byte beat and queue the code points it releases
  function automatic void decode_byte(input in_t beat);
    logic [7:0]  seq [0:3];
    out_t        step_q[$];
    out_t        res;
    logic [20:0] cp;
    logic        bad;
    int          n;
    int          pos;
    int          len;
    int          k;
    for (k = 0; k < hold_n; k++) seq[k] = hold_q[k];
    seq[hold_n] = beat.byte_in;
    n = hold_n + 1;
    pos = 0;
    while (pos < n && step_q.size() < MAX_RES) begin
      len = lead_length(seq[pos]);
      res = '0;
      if (len == 0) begin
        res.status = ST_BAD_LEAD;
        pos++;
      end else if (len == 1) begin
        res.code_point = {13'd0, seq[pos]};
        res.status = ST_OK;
        pos++;
      end else if (n - pos >= len) begin
        // lead payload bits shrink by one for each extra byte
        cp = '0;
        cp[7:0] = seq[pos] & (8'hFF >> (len + 1));
        bad = 1'b0;
        for (k = 1; k < len; k++) begin
          cp = {cp[14:0], seq[pos + k][5:0]};
          if (seq[pos + k][7:6] != 2'b10) bad = 1'b1;
        end
        res.code_point = cp;
        res.status = bad ? ST_BAD_CONT : ST_OK;
        pos += len;
      end else if (beat.final_byte) begin
        // string ended inside the sequence: drop the lead only
        res.status = ST_BAD_LEAD;
        pos++;
      end else begin
        break;
      end
      step_q.push_back(res);
    end
    // keep what is left unless the string is over
    hold_n = 0;
    if (!beat.final_byte) begin
      while (pos < n) begin
        hold_q[hold_n] = seq[pos];
        hold_n++;
        pos++;
      end
    end
    for (k = 0; k < step_q.size(); k++) begin
      res = step_q[k];
      if (k == step_q.size() - 1) begin
        res.last_of_run = 1'b1;
        res.string_done = beat.final_byte;
      end
      expected_cps.push_back(res);
    end
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 40) begin
      $display("mismatch at %0t: %s", $time, what);
    end
  endtask

  // Offer one byte beat and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_t beat;
    int  gap;
    beat.byte_in = b;
    beat.final_byte = fin;
    gap = draw_wait();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= beat;
    do @(posedge clk); while (byte_stall);
    decode_byte(beat);
    bytes_sent++;
  endtask

  // Send text_q as one string, final flag on its last byte
  task automatic send_text();
    int k;
    for (k = 0; k < text_q.size(); k++) begin
      send_byte(text_q[k], k == text_q.size() - 1);
    end
  endtask

  // Drop valid and wait until every expected code point is out
  task automatic wait_drained();
    byte_valid <= 1'b0;
    while (expected_cps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Continuation byte, now and then a malformed one
  function automatic void add_cont();
    if ($urandom_range(0, 11) == 0) begin
      text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
    end
  endfunction

  // Append one character: mostly well formed, sometimes noise or cut short
  function automatic void add_char();
    int kind;
    int len;
    int k;
    kind = $urandom_range(0, 15);
    if (kind <= 4) begin
      text_q.push_back(8'($urandom_range(0, 127)));
    end else if (kind <= 7) begin
      text_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
      add_cont();
    end else if (kind <= 10) begin
      text_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
      repeat (2) add_cont();
    end else if (kind <= 12) begin
      text_q.push_back(8'($urandom_range(8'hF0, 8'hF4)));
      repeat (3) add_cont();
    end else if (kind == 13) begin
      text_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 14) begin
      if ($urandom_range(0, 1) == 0) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
      else text_q.push_back(8'($urandom_range(8'hF5, 8'hFF)));
    end else begin
      len = $urandom_range(2, 4);
      case (len)
        2:       text_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        3:       text_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        default: text_q.push_back(8'($urandom_range(8'hF0, 8'hF4)));
      endcase
      for (k = $urandom_range(0, len - 2); k > 0; k--) add_cont();
    end
  endfunction

  // Result sink: random stall per beat, plus long hold-offs on request
  initial begin : result_sink
    int wait_n;
    forever begin
      if (long_hold > 0) begin
        cp_stall <= 1'b1;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
      end
      wait_n = draw_wait();
      if (wait_n > 0) begin
        cp_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      cp_stall <= 1'b0;
      do @(posedge clk); while (!cp_valid && long_hold == 0);
    end
  end

  // Compare each accepted beat with the oldest expected code point
  always @(posedge clk) begin
    if (!rst && cp_valid && !cp_stall) begin
      if (expected_cps.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, code point %h", cp_data.code_point));
      end else begin
        cp_want = expected_cps.pop_front();
        if (cp_data.code_point !== cp_want.code_point)
          report_mismatch($sformatf("code point %h, want %h",
                                    cp_data.code_point, cp_want.code_point));
        if (cp_data.status !== cp_want.status)
          report_mismatch($sformatf("status %0d, want %0d", cp_data.status, cp_want.status));
        if (cp_data.last_of_run !== cp_want.last_of_run)
          report_mismatch($sformatf("last_of_run %b, want %b",
                                    cp_data.last_of_run, cp_want.last_of_run));
        if (cp_data.string_done !== cp_want.string_done)
          report_mismatch($sformatf("string_done %b, want %b",
                                    cp_data.string_done, cp_want.string_done));
      end
    end
  end

  // Field extremes, every lead class, bad continuations, cut strings
  task automatic test_directed();
    text_q = '{8'h00, 8'h7F};
    send_text();
    text_q = '{8'hC2, 8'hA9, 8'hC0, 8'h80};
    send_text();
    text_q = '{8'hE2, 8'h82, 8'hAC};
    send_text();
    text_q = '{8'hF4, 8'hBF, 8'hBF, 8'hBF};
    send_text();
    text_q = '{8'hC3, 8'h41, 8'hF0, 8'h9F, 8'h00, 8'h80};
    send_text();
    text_q = '{8'h80, 8'hFF, 8'hF5};
    send_text();
    // string ends on three cut leads: one flush gives three results
    text_q = '{8'hF0, 8'hE2, 8'hC3};
    send_text();
    wait_drained();
  endtask

  // Random strings, quiet stretches and occasional full pauses
  task automatic test_random_text();
    int stop_at;
    int chars;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) wait_drained();
      text_q = {};
      for (chars = $urandom_range(1, 6); chars > 0; chars--) add_char();
      send_text();
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  // Hold the result side off while bytes keep coming, so the input stalls
  task automatic test_backpressure();
    int k;
    no_idle = 1'b1;
    long_hold = 120;
    for (k = 0; k < 3; k++) begin
      text_q = '{8'h41, 8'hE2, 8'h82, 8'hF0, 8'h9F, 8'hC3};
      send_text();
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  // Let the block run empty between strings, then pick up again
  task automatic test_pause_resume();
    text_q = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE2};
    send_text();
    wait_drained();
    text_q = '{8'hC2, 8'hA9, 8'h7A};
    send_text();
    wait_drained();
  endtask

  initial begin
    rst        <= 1'b1;
    byte_valid <= 1'b0;
    byte_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random_text();
    test_pause_resume();

    if (expected_cps.size() != 0) begin
      report_mismatch($sformatf("%0d code points never arrived", expected_cps.size()));
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
